@@ rtl/fcs_pkg.sv @@
// Shared constants and types for the fire cell shader.
package fcs_pkg;

  // Largest grid, in cells, that still produces output.
  localparam int unsigned MAX_CELLS = 1024;

  // Widths of the configuration port.
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  // Values the configuration registers take after reset.
  localparam logic [10:0] GRID_WIDTH_RST    = 11'd16;
  localparam logic [10:0] GRID_HEIGHT_RST   = 11'd16;
  localparam logic [7:0]  COOLING_GAIN_RST  = 8'd64;
  localparam logic        REVERSE_STRIP_RST = 1'b0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH    = 2'd0,
    REG_GRID_HEIGHT   = 2'd1,
    REG_COOLING_GAIN  = 2'd2,
    REG_REVERSE_STRIP = 2'd3
  } cfg_reg_t;

  // Colour wheel sectors, one sixth of the hue circle each.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

endpackage

@@ rtl/fcs_hsv.sv @@
// Two-stage HSV to RGB conversion with a fixed saturation of 255/256.
module fcs_hsv import fcs_pkg::*; (
  input  logic       clk,
  input  logic [7:0] val,
  input  logic [7:0] hue,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic [10:0] h6;
  logic [7:0]  fr;
  logic [15:0] fr255;
  logic [15:0] vm_c;
  logic [16:0] kq_c;
  logic [15:0] kt_c;

  logic [15:0] a_vm;
  logic [16:0] a_kq;
  logic [15:0] a_kt;
  sector_t     a_sec;

  logic [32:0] q_prod;
  logic [31:0] t_prod;
  logic [7:0]  ch_v;
  logic [7:0]  ch_p;
  logic [7:0]  ch_q;
  logic [7:0]  ch_t;

  // Split the hue into a sector and a fraction, and form the channel weights.
  always_comb begin
    h6    = {3'b000, hue} * 11'd6;
    fr    = h6[7:0];
    fr255 = {fr, 8'h00} - {8'h00, fr};
    kq_c  = 17'h10000 - {1'b0, fr255};
    kt_c  = 16'd256 + fr255;
    vm_c  = {val, 8'h00} - {8'h00, val};
  end

  always_ff @(posedge clk) begin
    a_vm  <= vm_c;
    a_kq  <= kq_c;
    a_kt  <= kt_c;
    a_sec <= sector_t'(h6[10:8]);
  end

  // Scale the weights by value*255. The products stay below 255 * 2^24, so the
  // top byte needs no saturation. The p term is value*255*256 / 2^24, which is
  // always below one and therefore floors to zero.
  always_comb begin
    q_prod = {16'h0000, a_vm} * {16'h0000, a_kq};
    t_prod = {16'h0000, a_vm} * {16'h0000, a_kt};
    ch_v   = a_vm[15:8];
    ch_p   = 8'h00;
    ch_q   = q_prod[31:24];
    ch_t   = t_prod[31:24];
  end

  // Route the channels by sector into the output registers.
  always_ff @(posedge clk) begin
    case (a_sec)
      SEC_RED_YELLOW: begin
        red <= ch_v; green <= ch_t; blue <= ch_p;
      end
      SEC_YELLOW_GREEN: begin
        red <= ch_q; green <= ch_v; blue <= ch_p;
      end
      SEC_GREEN_CYAN: begin
        red <= ch_p; green <= ch_v; blue <= ch_t;
      end
      SEC_CYAN_BLUE: begin
        red <= ch_p; green <= ch_q; blue <= ch_v;
      end
      SEC_BLUE_MAGENTA: begin
        red <= ch_t; green <= ch_p; blue <= ch_v;
      end
      default: begin
        red <= ch_v; green <= ch_p; blue <= ch_q;
      end
    endcase
  end

endmodule

@@ rtl/fire_cell_shader.sv @@
// Fire cell shader: blends, cools and colours one flame cell per transaction.
// Pipeline: a result reaches the output ports after the start transaction is taken,
// through four register stages (blend products, value and index, colour weights and
// mirroring, channel products and output registers).
// Throughput: one cell per clock; busy is always low and the receiver cannot stall.
// Reset: synchronous rst clears the stage valid bits and loads the register defaults.
module fire_cell_shader import fcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [9:0]            row,
  input  logic [9:0]            col,
  input  logic [7:0]            heat_here,
  input  logic [7:0]            heat_below,
  input  logic [7:0]            phase,
  input  logic [7:0]            cool_mask,
  input  logic [7:0]            hue,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [9:0]            led_index,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue
);

  logic [10:0] grid_width;
  logic [10:0] grid_height;
  logic [7:0]  cooling_gain;
  logic        reverse_strip;

  logic        accept;

  logic [8:0]  phase_inv;
  logic [16:0] mix_a_c;
  logic [15:0] mix_b_c;
  logic [15:0] cool_c;
  logic [10:0] flip_c;
  logic [21:0] total_c;

  logic        s1_valid;
  logic        s1_in_grid;
  logic        s1_total_ok;
  logic [15:0] s1_mix_a;
  logic [15:0] s1_mix_b;
  logic [15:0] s1_cool;
  logic [9:0]  s1_flip;
  logic [9:0]  s1_total_lo;
  logic [9:0]  s1_col;
  logic [7:0]  s1_hue;

  logic [16:0] num_c;
  logic [17:0] cool4_c;
  logic [17:0] diff_c;
  logic [7:0]  val_c;
  logic [19:0] row_base_c;

  logic        s2_valid;
  logic [7:0]  s2_val;
  logic [7:0]  s2_hue;
  logic [9:0]  s2_idx;
  logic [9:0]  s2_total_lo;

  logic        s3_valid;
  logic [9:0]  s3_idx;

  // The pipeline takes a cell in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= GRID_WIDTH_RST;
      grid_height   <= GRID_HEIGHT_RST;
      cooling_gain  <= COOLING_GAIN_RST;
      reverse_strip <= REVERSE_STRIP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:    grid_width    <= cfg_data;
        REG_GRID_HEIGHT:   grid_height   <= cfg_data;
        REG_COOLING_GAIN:  cooling_gain  <= cfg_data[7:0];
        REG_REVERSE_STRIP: reverse_strip <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: blend and cooling products, grid checks and the flipped row.
  always_comb begin
    phase_inv = 9'd256 - {1'b0, phase};
    mix_a_c   = {8'h00, phase_inv} * {9'h000, heat_here};
    mix_b_c   = {8'h00, phase} * {8'h00, heat_below};
    cool_c    = {8'h00, cool_mask} * {8'h00, cooling_gain};
    flip_c    = grid_height - {1'b0, row} - 11'd1;
    total_c   = {11'h000, grid_width} * {11'h000, grid_height};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_mix_a    <= mix_a_c[15:0];
    s1_mix_b    <= mix_b_c;
    s1_cool     <= cool_c;
    s1_flip     <= flip_c[9:0];
    s1_total_lo <= total_c[9:0];
    s1_total_ok <= (total_c <= 22'(MAX_CELLS));
    s1_in_grid  <= ({1'b0, row} < grid_height) && ({1'b0, col} < grid_width);
    s1_col      <= col;
    s1_hue      <= hue;
  end

  // Stage 2: cooled value with clamping, and the forward LED index.
  always_comb begin
    num_c      = {1'b0, s1_mix_a} + {1'b0, s1_mix_b};
    cool4_c    = {s1_cool, 2'b00};
    diff_c     = {1'b0, num_c} - cool4_c;
    if ({1'b0, num_c} > cool4_c) begin
      val_c = (|diff_c[17:16]) ? 8'hFF : diff_c[15:8];
    end else begin
      val_c = 8'h00;
    end
    row_base_c = {10'h000, s1_flip} * {10'h000, grid_width[9:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_in_grid && s1_total_ok;
    end
  end

  always_ff @(posedge clk) begin
    s2_val      <= val_c;
    s2_hue      <= s1_hue;
    s2_idx      <= row_base_c[9:0] + s1_col;
    s2_total_lo <= s1_total_lo;
  end

  // Stage 3: mirror the index across the strip when requested.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_idx <= reverse_strip ? (s2_total_lo - 10'd1 - s2_idx) : s2_idx;
  end

  // Stage 4: output registers for the strobe and the index.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    led_index <= s3_idx;
  end

  // Colour conversion runs alongside stages 3 and 4.
  fcs_hsv u_hsv (
    .clk   (clk),
    .val   (s2_val),
    .hue   (s2_hue),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

`ifndef SYNTHESIS
  // Every result strobe traces back to an earlier accepted start transaction.
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching start transaction");

  // A delivered index always lies inside the configured grid.
  a_index_in_grid: assert property (@(posedge clk) disable iff (rst)
    done |-> (22'(led_index) < ({11'h000, grid_width} * {11'h000, grid_height})))
    else $error("LED index outside the grid");

  // The first stage never lets a cell through when the grid is oversized.
  a_oversize_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_total_ok) |=> !s2_valid)
    else $error("cell passed with an oversized grid");
`endif

endmodule
